// ===== design/cdc_pkg.sv =====
`timescale 1ns / 1ps
package cdc_pkg;
  localparam int MaxChunkBits = 12;
  localparam int BitSkew      = 2;
  localparam int CfgBitsMin   = 3;
  localparam int LenW         = 15;
  localparam logic [3:0] ChunkBitsReset = 4'd12;
endpackage

// ===== design/content_defined_chunker.sv =====
`timescale 1ns / 1ps
// Content-defined chunker. Bytes are buffered in a ring of 2^(MAX_CHUNK_BITS+2)
// entries; once max bytes are held, a rolling checksum search over the ring
// finds the cut and one chunk_length is issued. A byte that triggers no cut
// passes from C_IDLE through C_CHECK back to C_IDLE; a cutting byte goes on to
// C_SCAN, which seeds the checksum and then rolls it until a cut point is found
// or the chunk runs to max, through the single ring read port shared by seeding
// and the rolling scan (S_OUT, S_IN and S_CALC per scanned position).
// End of stream issues the tail length with last_chunk set.
module content_defined_chunker #(
  parameter int MAX_CHUNK_BITS = cdc_pkg::MaxChunkBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] chunk_length,
  output logic        last_chunk,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  import cdc_pkg::*;
  localparam int AW = MAX_CHUNK_BITS + BitSkew;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001, C_CHECK = 3'b010, C_SCAN = 3'b100
  } ctl_t;

  ctl_t        state;
  logic [3:0]  chunk_bits;
  logic [AW:0] fill_count;
  logic [AW-1:0] chunk_start;
  logic [4:0]  bits;
  logic [AW:0] hi;
  logic        we, scan_start, scan_done;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  rdata;
  logic [AW:0] cut;

  always_comb begin
    bits = 5'(chunk_bits);
    if (chunk_bits < 4'(CfgBitsMin)) bits = 5'(CfgBitsMin);
    if (32'(chunk_bits) > MAX_CHUNK_BITS) bits = 5'(MAX_CHUNK_BITS);
  end
  assign hi = (AW+1)'(1) << (bits + 5'(BitSkew));

  assign in_ready = state == C_IDLE && !out_valid;
  assign we = in_valid && in_ready && !kind;
  assign waddr = chunk_start + fill_count[AW-1:0];
  assign scan_start = state == C_CHECK && fill_count >= hi;

  cdc_ram #(.Width(8), .Depth(1 << AW)) u_ring (
    .clk(clk), .we(we), .waddr(waddr), .wdata(data_byte),
    .raddr(raddr), .rdata(rdata)
  );

  cdc_scan #(.MaxChunkBits(MAX_CHUNK_BITS)) u_scan (
    .clk(clk), .rst(rst), .start(scan_start), .bits(bits), .base(chunk_start),
    .raddr(raddr), .rdata(rdata), .done(scan_done), .cut(cut)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      chunk_bits <= ChunkBitsReset;
      fill_count <= '0;
      chunk_start <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) chunk_bits <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        C_IDLE: if (in_valid && in_ready) begin
          if (kind) begin
            chunk_length <= LenW'(fill_count);
            last_chunk <= 1'b1;
            out_valid <= 1'b1;
            fill_count <= '0;
            chunk_start <= '0;
          end else begin
            if (fill_count < (AW+1)'(1 << AW)) fill_count <= fill_count + 1'b1;
            state <= C_CHECK;
          end
        end
        C_CHECK: state <= (fill_count >= hi) ? C_SCAN : C_IDLE;
        C_SCAN: if (scan_done) begin
          chunk_length <= LenW'(cut);
          last_chunk <= 1'b0;
          out_valid <= 1'b1;
          chunk_start <= chunk_start + cut[AW-1:0];
          fill_count <= fill_count - cut;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule

// ===== design/cdc_ram.sv =====
`timescale 1ns / 1ps
module cdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/cdc_scan.sv =====
`timescale 1ns / 1ps
// Cut search: seeding reads one ring byte per cycle; the scan fetches the leaving
// byte (S_OUT) and then the entering byte (S_IN) through the single read port.
module cdc_scan #(
  parameter int MaxChunkBits = cdc_pkg::MaxChunkBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [4:0]                           bits,
  input  logic [MaxChunkBits+cdc_pkg::BitSkew-1:0] base,
  output logic [MaxChunkBits+cdc_pkg::BitSkew-1:0] raddr,
  input  logic [7:0]                           rdata,
  output logic                                 done,
  output logic [MaxChunkBits+cdc_pkg::BitSkew:0]   cut
);
  import cdc_pkg::*;
  localparam int AW = MaxChunkBits + BitSkew;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SEED = 6'b000010, S_OUT = 6'b000100,
    S_IN   = 6'b001000, S_CALC = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t      state;
  logic [AW:0] pos;      // seed index or scan position
  logic [AW:0] rdpos;
  logic [31:0] a, b;
  logic [7:0]  leaving;
  logic        seed_pend;
  logic [AW:0] lo, hi;
  logic [31:0] mask, na, nb;
  logic [31:0] seed_a, seed_b;

  assign lo   = (AW+1)'(1) << (bits - 5'(BitSkew));
  assign hi   = (AW+1)'(1) << (bits + 5'(BitSkew));
  assign mask = (32'd1 << bits) - 32'd1;
  assign raddr = base + rdpos[AW-1:0];
  assign na = a - 32'(leaving) + 32'(rdata);
  assign nb = b - (32'(lo) + 32'd1) * 32'(leaving) + na;
  assign done = state == S_DONE;
  // rdata belongs to the address issued last cycle (pos-1)
  assign seed_a = seed_pend ? a + 32'(rdata) : a;
  assign seed_b = seed_pend ? b + (32'(lo) - 32'(pos) + 32'd2) * 32'(rdata) : b;

  always_comb begin
    rdpos = pos;
    if (state == S_OUT) rdpos = pos - lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seed_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_SEED; pos <= '0; a <= 32'd1; b <= '0; seed_pend <= 1'b0;
        end
        S_SEED: begin
          if (pos == lo) begin
            a <= seed_a & mask;
            b <= seed_b & mask;
            state <= S_OUT;
            seed_pend <= 1'b0;
          end else begin
            a <= seed_a;
            b <= seed_b;
            pos <= pos + 1'b1;
            seed_pend <= 1'b1;
          end
        end
        S_OUT: state <= S_IN;   // address of leaving byte issued
        S_IN: begin             // leaving byte arrives, entering address issued
          leaving <= rdata;
          state <= S_CALC;
        end
        S_CALC: begin
          if (((na + (nb << 16)) & mask) == 32'd0) begin
            cut <= pos; state <= S_DONE;
          end else begin
            a <= na; b <= nb;
            if (pos + 1'b1 == hi) begin
              cut <= hi; state <= S_DONE;
            end else begin
              pos <= pos + 1'b1; state <= S_OUT;
            end
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
